// File: rtl/midi_track_event_parser_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the MIDI track event parser
// Shared concurrent assertion forms, clocked, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef MIDI_TRACK_EVENT_PARSER_UNIT_ASSERT_SVH
`define MIDI_TRACK_EVENT_PARSER_UNIT_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define MTEP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MTEP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   `MTEP_ASSERT(label, clk, rst, (ante) |=> (cons), msg)

`endif

// File: rtl/mtep_pkg.sv
// ----------------------------------------------------------------------------
// mtep_pkg
// Types, codes and helpers shared by the MIDI track event parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mtep_pkg;

   localparam int QUEUE_DEPTH = 2;

   // parser phases
   typedef enum logic [3:0] {
      PH_DELTA     = 4'd0,
      PH_STATUS    = 4'd1,
      PH_PARAM1    = 4'd2,
      PH_PARAM2    = 4'd3,
      PH_META_KIND = 4'd4,
      PH_META_LEN  = 4'd5,
      PH_SYSEX_LEN = 4'd6,
      PH_PAYLOAD   = 4'd7,
      PH_SKIP_ONE  = 4'd8
   } phase_type;

   // byte classes as seen in the status position
   typedef enum logic [1:0] {
      BC_DATA   = 2'd0,
      BC_STATUS = 2'd1,
      BC_META   = 2'd2,
      BC_SYSEX  = 2'd3
   } byte_class_type;

   // result event kinds
   localparam logic [1:0] EV_NOTE_ON  = 2'd0;
   localparam logic [1:0] EV_NOTE_OFF = 2'd1;
   localparam logic [1:0] EV_TEMPO    = 2'd2;

   // special bytes
   localparam logic [7:0] BYTE_META       = 8'hFF;
   localparam logic [7:0] BYTE_SYSEX      = 8'hF0;
   localparam logic [7:0] BYTE_SYSEX_ESC  = 8'hF7;
   localparam logic [7:0] META_TEMPO      = 8'h51;
   localparam logic [27:0] TEMPO_LEN      = 28'd3;

   // channel command nibbles
   localparam logic [3:0] CMD_NOTE_OFF  = 4'h8;
   localparam logic [3:0] CMD_NOTE_ON   = 4'h9;
   localparam logic [3:0] CMD_POLY_AT   = 4'hA;
   localparam logic [3:0] CMD_CONTROL   = 4'hB;
   localparam logic [3:0] CMD_PROGRAM   = 4'hC;
   localparam logic [3:0] CMD_CHAN_AT   = 4'hD;
   localparam logic [3:0] CMD_PITCH     = 4'hE;

   // one classified byte in the front-to-back queue
   typedef struct packed {
      logic [7:0]     data_byte;
      logic           track_start;
      byte_class_type byte_class;
      logic [1:0]     own_params;
   } entry_type;

   // number of parameter bytes of a channel command
   function automatic logic [1:0] cmd_param_len(input logic [3:0] cmd);
      logic [1:0] cnt;
      case (cmd)
         CMD_NOTE_OFF, CMD_NOTE_ON, CMD_POLY_AT, CMD_CONTROL, CMD_PITCH: cnt = 2'd2;
         CMD_PROGRAM, CMD_CHAN_AT: cnt = 2'd1;
         default: cnt = 2'd0;
      endcase
      return cnt;
   endfunction

endpackage

// File: rtl/mtep_channel_ifs.sv
// ----------------------------------------------------------------------------
// mtep channel interfaces
// Valid/ready channels for track bytes in and parsed events out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mtep_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       track_start;

   modport source (output valid, output data_byte, output track_start, input ready);
   modport sink   (input valid, input data_byte, input track_start, output ready);
endinterface

interface mtep_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  event_kind;
   logic [31:0] event_tick;
   logic [7:0]  note_pitch;
   logic [7:0]  note_velocity;
   logic [23:0] tempo_us_per_beat;

   modport source (output valid, output event_kind, output event_tick, output note_pitch,
                   output note_velocity, output tempo_us_per_beat, input ready);
   modport sink   (input valid, input event_kind, input event_tick, input note_pitch,
                   input note_velocity, input tempo_us_per_beat, output ready);
endinterface

// File: rtl/mtep_front.sv
// ----------------------------------------------------------------------------
// mtep_front
// Accepts track bytes and classifies them for the parser queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtep_front (
   mtep_req_if.sink             req_bus,
   input  logic                 q_ready,
   output logic                 push,
   output mtep_pkg::entry_type  push_entry
);

   logic [7:0] b;

   assign b            = req_bus.data_byte;
   assign req_bus.ready = q_ready;
   assign push         = req_bus.valid & q_ready;

   always_comb begin
      push_entry.data_byte   = b;
      push_entry.track_start = req_bus.track_start;
      push_entry.own_params  = mtep_pkg::cmd_param_len(b[7:4]);
      if (b == mtep_pkg::BYTE_META) begin
         push_entry.byte_class = mtep_pkg::BC_META;
      end else if (b == mtep_pkg::BYTE_SYSEX || b == mtep_pkg::BYTE_SYSEX_ESC) begin
         push_entry.byte_class = mtep_pkg::BC_SYSEX;
      end else if (b[7]) begin
         push_entry.byte_class = mtep_pkg::BC_STATUS;
      end else begin
         push_entry.byte_class = mtep_pkg::BC_DATA;
      end
   end

endmodule

// File: rtl/mtep_queue.sv
// ----------------------------------------------------------------------------
// mtep_queue
// Short FIFO of classified bytes between front and parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtep_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  mtep_pkg::entry_type  push_entry,
   output logic                 q_ready,
   input  logic                 pop,
   output logic                 q_valid,
   output mtep_pkg::entry_type  q_entry
);

   localparam int PTR_W = (mtep_pkg::QUEUE_DEPTH > 1) ? $clog2(mtep_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(mtep_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(mtep_pkg::QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(mtep_pkg::QUEUE_DEPTH);

   mtep_pkg::entry_type slot_ff [mtep_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign q_ready = (count_ff != FULL_CNT);
   assign q_valid = (count_ff != '0);
   assign q_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: rtl/mtep_back.sv
// ----------------------------------------------------------------------------
// mtep_back
// Track parser state machine and registered event output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtep_back #(
   parameter int MAX_VLQ_BYTES = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  mtep_pkg::entry_type  q_entry,
   output logic                 pop,
   mtep_rsp_if.source           rsp_bus
);

   `include "midi_track_event_parser_unit_assert.svh"

   localparam int VLQ_CNT_W = $clog2(MAX_VLQ_BYTES + 1);
   localparam logic [VLQ_CNT_W-1:0] MAX_CNT = VLQ_CNT_W'(MAX_VLQ_BYTES);

   mtep_pkg::phase_type phase_ff, phase_in, eff_phase;
   logic [27:0]          vlq_ff, vlq_in, eff_vlq, vlq_next;
   logic [VLQ_CNT_W-1:0] vlq_cnt_ff, vlq_cnt_in, eff_cnt, cnt_next;
   logic                 vlq_done;
   logic [31:0]          tick_ff, tick_in, eff_tick;
   logic [7:0]           rs_ff, rs_in, eff_rs;
   logic [1:0]           rs_params;
   logic [7:0]           meta_ff, meta_in;
   logic [27:0]          skip_ff, skip_in;
   logic                 tempo_flag_ff, tempo_flag_in;
   logic [7:0]           first_ff, first_in;
   logic [23:0]          taccum_ff, taccum_in;

   logic                 emit;
   logic [1:0]           emit_kind;
   logic [7:0]           emit_pitch;
   logic [7:0]           emit_vel;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_kind_ff;
   logic [31:0]          rsp_tick_ff;
   logic [7:0]           rsp_pitch_ff;
   logic [7:0]           rsp_vel_ff;
   logic [23:0]          rsp_tempo_ff;

   logic [7:0]           b;
   logic                 ts;

   assign b   = q_entry.data_byte;
   assign ts  = q_entry.track_start;
   // output slot is free, or frees up this cycle
   assign pop = q_valid && (!rsp_valid_ff || rsp_bus.ready);

   // state as seen after a track start
   always_comb begin
      eff_phase = ts ? mtep_pkg::PH_DELTA : phase_ff;
      eff_vlq   = ts ? '0 : vlq_ff;
      eff_cnt   = ts ? '0 : vlq_cnt_ff;
      eff_tick  = ts ? '0 : tick_ff;
      eff_rs    = ts ? '0 : rs_ff;
      rs_params = mtep_pkg::cmd_param_len(eff_rs[7:4]);
      vlq_next  = {eff_vlq[20:0], b[6:0]};
      cnt_next  = eff_cnt + VLQ_CNT_W'(1);
      vlq_done  = !b[7] || (cnt_next >= MAX_CNT);
   end

   always_comb begin
      phase_in      = phase_ff;
      vlq_in        = vlq_ff;
      vlq_cnt_in    = vlq_cnt_ff;
      tick_in       = tick_ff;
      rs_in         = rs_ff;
      meta_in       = meta_ff;
      skip_in       = skip_ff;
      tempo_flag_in = tempo_flag_ff;
      first_in      = first_ff;
      taccum_in     = taccum_ff;
      emit          = 1'b0;
      emit_kind     = mtep_pkg::EV_NOTE_ON;
      emit_pitch    = '0;
      emit_vel      = '0;
      if (pop) begin
         phase_in   = eff_phase;
         vlq_in     = eff_vlq;
         vlq_cnt_in = eff_cnt;
         tick_in    = eff_tick;
         rs_in      = eff_rs;
         case (eff_phase)
            mtep_pkg::PH_STATUS: begin
               case (q_entry.byte_class)
                  mtep_pkg::BC_META:  phase_in = mtep_pkg::PH_META_KIND;
                  mtep_pkg::BC_SYSEX: phase_in = mtep_pkg::PH_SYSEX_LEN;
                  mtep_pkg::BC_STATUS: begin
                     rs_in    = b;
                     phase_in = (q_entry.own_params == 2'd0) ? mtep_pkg::PH_SKIP_ONE
                                                             : mtep_pkg::PH_PARAM1;
                  end
                  default: begin
                     // data byte under running status; one-parameter commands
                     // never produce a result
                     if (rs_params == 2'd2) begin
                        first_in = b;
                        phase_in = mtep_pkg::PH_PARAM2;
                     end else begin
                        phase_in = mtep_pkg::PH_DELTA;
                     end
                  end
               endcase
            end
            mtep_pkg::PH_PARAM1: begin
               if (rs_params == 2'd1) begin
                  phase_in = mtep_pkg::PH_DELTA;
               end else begin
                  first_in = b;
                  phase_in = mtep_pkg::PH_PARAM2;
               end
            end
            mtep_pkg::PH_PARAM2: begin
               phase_in   = mtep_pkg::PH_DELTA;
               emit_pitch = first_ff;
               emit_vel   = b;
               if (eff_rs[7:4] == mtep_pkg::CMD_NOTE_ON && b != '0) begin
                  emit      = 1'b1;
                  emit_kind = mtep_pkg::EV_NOTE_ON;
               end else if (eff_rs[7:4] == mtep_pkg::CMD_NOTE_ON ||
                            eff_rs[7:4] == mtep_pkg::CMD_NOTE_OFF) begin
                  emit      = 1'b1;
                  emit_kind = mtep_pkg::EV_NOTE_OFF;
               end
            end
            mtep_pkg::PH_META_KIND: begin
               meta_in  = b;
               phase_in = mtep_pkg::PH_META_LEN;
            end
            mtep_pkg::PH_META_LEN, mtep_pkg::PH_SYSEX_LEN: begin
               vlq_in     = vlq_done ? '0 : vlq_next;
               vlq_cnt_in = vlq_done ? '0 : cnt_next;
               if (vlq_done) begin
                  tempo_flag_in = (eff_phase == mtep_pkg::PH_META_LEN) &&
                                  (meta_ff == mtep_pkg::META_TEMPO) &&
                                  (vlq_next == mtep_pkg::TEMPO_LEN);
                  taccum_in     = '0;
                  skip_in       = vlq_next;
                  phase_in      = (vlq_next == '0) ? mtep_pkg::PH_DELTA
                                                   : mtep_pkg::PH_PAYLOAD;
               end
            end
            mtep_pkg::PH_PAYLOAD: begin
               if (tempo_flag_ff) begin
                  taccum_in = {taccum_ff[15:0], b};
               end
               skip_in = skip_ff - 28'd1;
               if (skip_in == '0) begin
                  phase_in = mtep_pkg::PH_DELTA;
                  if (tempo_flag_ff) begin
                     tempo_flag_in = 1'b0;
                     emit          = 1'b1;
                     emit_kind     = mtep_pkg::EV_TEMPO;
                  end
               end
            end
            mtep_pkg::PH_SKIP_ONE: phase_in = mtep_pkg::PH_DELTA;
            default: begin
               // delta time
               vlq_in     = vlq_done ? '0 : vlq_next;
               vlq_cnt_in = vlq_done ? '0 : cnt_next;
               if (vlq_done) begin
                  tick_in  = eff_tick + {4'b0000, vlq_next};
                  phase_in = mtep_pkg::PH_STATUS;
               end else begin
                  phase_in = mtep_pkg::PH_DELTA;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= mtep_pkg::PH_DELTA;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vlq_ff        <= '0;
         vlq_cnt_ff    <= '0;
         tick_ff       <= '0;
         rs_ff         <= '0;
         meta_ff       <= '0;
         skip_ff       <= '0;
         tempo_flag_ff <= 1'b0;
         first_ff      <= '0;
         taccum_ff     <= '0;
      end else begin
         vlq_ff        <= vlq_in;
         vlq_cnt_ff    <= vlq_cnt_in;
         tick_ff       <= tick_in;
         rs_ff         <= rs_in;
         meta_ff       <= meta_in;
         skip_ff       <= skip_in;
         tempo_flag_ff <= tempo_flag_in;
         first_ff      <= first_in;
         taccum_ff     <= taccum_in;
      end
   end

   // output register
   always_comb begin
      if (pop && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emit) begin
         rsp_kind_ff  <= emit_kind;
         rsp_tick_ff  <= eff_tick;
         rsp_pitch_ff <= emit_pitch;
         rsp_vel_ff   <= emit_vel;
         rsp_tempo_ff <= (emit_kind == mtep_pkg::EV_TEMPO) ? taccum_in : '0;
      end
   end

   assign rsp_bus.valid             = rsp_valid_ff;
   assign rsp_bus.event_kind        = rsp_kind_ff;
   assign rsp_bus.event_tick        = rsp_tick_ff;
   assign rsp_bus.note_pitch        = rsp_pitch_ff;
   assign rsp_bus.note_velocity     = rsp_vel_ff;
   assign rsp_bus.tempo_us_per_beat = rsp_tempo_ff;

   `MTEP_ASSERT(a_payload_left, clock, reset, (phase_ff == mtep_pkg::PH_PAYLOAD) |-> (skip_ff != '0), "payload phase with nothing left to skip")
   `MTEP_ASSERT(a_vlq_count_bound, clock, reset, vlq_cnt_ff < MAX_CNT, "VLQ byte count reached its limit without ending")
   `MTEP_ASSERT(a_no_overwrite, clock, reset, (rsp_valid_ff && !rsp_bus.ready) |-> !pop, "parser advanced while result transaction stalled")
   `MTEP_ASSERT(a_tempo_no_note, clock, reset, (rsp_valid_ff && rsp_kind_ff == mtep_pkg::EV_TEMPO) |-> (rsp_pitch_ff == '0 && rsp_vel_ff == '0), "tempo event with note fields set")
   `MTEP_ASSERT_NEXT(a_emit_lands, clock, reset, pop && emit, rsp_valid_ff && rsp_tick_ff == $past(eff_tick), "emitted event not presented with its tick")

endmodule

// File: rtl/midi_track_event_parser_unit.sv
// Path: an accepted byte is written into a queue slot; the parser step on that
//   byte loads its event into the output register, which drives rsp_bus.valid.
// Throughput: one byte per cycle sustained while the result side does not stall;
//   a 2-entry queue decouples the sides. Reset (synchronous, active high): queue
//   emptied, parser back to delta time, tick and running status zero, no result pending.
// ----------------------------------------------------------------------------
// midi_track_event_parser_unit
// Parses MIDI track chunk bytes into note-on, note-off and tempo events.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module midi_track_event_parser_unit #(
   parameter int MAX_VLQ_BYTES = 4
) (
   input  logic         clock,
   input  logic         reset,
   mtep_req_if.sink     req_bus,
   mtep_rsp_if.source   rsp_bus
);

   logic                push;
   mtep_pkg::entry_type push_entry;
   logic                q_ready;
   logic                q_valid;
   mtep_pkg::entry_type q_entry;
   logic                pop;

   mtep_front u_front (
      .req_bus    (req_bus),
      .q_ready    (q_ready),
      .push       (push),
      .push_entry (push_entry)
   );

   mtep_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .q_ready    (q_ready),
      .pop        (pop),
      .q_valid    (q_valid),
      .q_entry    (q_entry)
   );

   mtep_back #(
      .MAX_VLQ_BYTES (MAX_VLQ_BYTES)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_entry (q_entry),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

endmodule

// File: verif/mtep_event_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtep_event_checker
// Watches the byte and event channels of the track event parser. It keeps
// its own parse of the byte stream and checks every event the block hands
// out against the oldest predicted one, field by field.
// ----------------------------------------------------------------------------

module mtep_event_checker #(
   parameter int MAX_VLQ_BYTES = 4
) (
   input  logic clock,
   input  logic reset,
   mtep_req_if  req_bus,
   mtep_rsp_if  rsp_bus,
   output int   fail_count,
   output int   pending_count
);

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] tick;
      logic [7:0]  pitch;
      logic [7:0]  velocity;
      logic [23:0] tempo;
   } track_event_type;

   track_event_type predicted_events[$];
   int              errors = 0;

   // parser state as predicted
   mtep_pkg::phase_type phase;
   logic [27:0] vlq_acc;
   logic [2:0]  vlq_cnt;
   logic [31:0] tick;
   logic [7:0]  run_status;
   logic [7:0]  meta_kind;
   logic [27:0] skip_left;
   logic        tempo_meta;
   logic [7:0]  param1;
   logic [23:0] tempo_acc;

   function automatic void clear_parser();
      phase      = mtep_pkg::PH_DELTA;
      vlq_acc    = '0;
      vlq_cnt    = '0;
      tick       = '0;
      run_status = '0;
      meta_kind  = '0;
      skip_left  = '0;
      tempo_meta = 1'b0;
      param1     = '0;
      tempo_acc  = '0;
   endfunction

   function automatic logic [1:0] params_of(input logic [7:0] status);
      case (status[7:4])
         mtep_pkg::CMD_NOTE_OFF, mtep_pkg::CMD_NOTE_ON, mtep_pkg::CMD_POLY_AT,
         mtep_pkg::CMD_CONTROL, mtep_pkg::CMD_PITCH: return 2'd2;
         mtep_pkg::CMD_PROGRAM, mtep_pkg::CMD_CHAN_AT: return 2'd1;
         default: return 2'd0;
      endcase
   endfunction

   function automatic void push_event(input logic [1:0] kind, input logic [7:0] pitch,
                                      input logic [7:0] velocity, input logic [23:0] tempo);
      track_event_type ev;
      ev.kind     = kind;
      ev.tick     = tick;
      ev.pitch    = pitch;
      ev.velocity = velocity;
      ev.tempo    = tempo;
      predicted_events = {predicted_events, ev};
   endfunction

   // last parameter byte of a channel event
   function automatic void close_channel(input logic [7:0] p1, input logic [7:0] p2);
      phase = mtep_pkg::PH_DELTA;
      if (run_status[7:4] == mtep_pkg::CMD_NOTE_ON && p2 != 8'h00)
         push_event(mtep_pkg::EV_NOTE_ON, p1, p2, 24'h0);
      else if (run_status[7:4] == mtep_pkg::CMD_NOTE_ON ||
               run_status[7:4] == mtep_pkg::CMD_NOTE_OFF)
         push_event(mtep_pkg::EV_NOTE_OFF, p1, p2, 24'h0);
   endfunction

   function automatic bit vlq_done(input logic [7:0] b, output logic [27:0] value);
      vlq_acc = {vlq_acc[20:0], b[6:0]};
      vlq_cnt = vlq_cnt + 3'd1;
      value   = vlq_acc;
      if (!b[7] || vlq_cnt >= MAX_VLQ_BYTES) begin
         vlq_acc = '0;
         vlq_cnt = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void open_payload(input logic [27:0] len, input logic tempo_ok);
      tempo_meta = tempo_ok;
      tempo_acc  = '0;
      skip_left  = len;
      phase      = (len == 28'd0) ? mtep_pkg::PH_DELTA : mtep_pkg::PH_PAYLOAD;
   endfunction

   function automatic void predict_byte(input logic [7:0] b, input logic start);
      logic [27:0] len;
      logic [1:0]  cnt;
      if (start) begin
         tick       = '0;
         run_status = '0;
         phase      = mtep_pkg::PH_DELTA;
         vlq_acc    = '0;
         vlq_cnt    = '0;
      end
      case (phase)
         mtep_pkg::PH_STATUS: begin
            if (b == mtep_pkg::BYTE_META) begin
               phase = mtep_pkg::PH_META_KIND;
            end else if (b == mtep_pkg::BYTE_SYSEX || b == mtep_pkg::BYTE_SYSEX_ESC) begin
               phase = mtep_pkg::PH_SYSEX_LEN;
            end else if (b[7]) begin
               run_status = b;
               phase = (params_of(b) == 2'd0) ? mtep_pkg::PH_SKIP_ONE : mtep_pkg::PH_PARAM1;
            end else begin
               // data byte: running status applies
               cnt = params_of(run_status);
               if (cnt == 2'd0) begin
                  phase = mtep_pkg::PH_DELTA;
               end else if (cnt == 2'd1) begin
                  close_channel(b, 8'h00);
               end else begin
                  param1 = b;
                  phase  = mtep_pkg::PH_PARAM2;
               end
            end
         end
         mtep_pkg::PH_PARAM1: begin
            if (params_of(run_status) == 2'd1) begin
               close_channel(b, 8'h00);
            end else begin
               param1 = b;
               phase  = mtep_pkg::PH_PARAM2;
            end
         end
         mtep_pkg::PH_PARAM2: close_channel(param1, b);
         mtep_pkg::PH_META_KIND: begin
            meta_kind = b;
            phase     = mtep_pkg::PH_META_LEN;
         end
         mtep_pkg::PH_META_LEN: begin
            if (vlq_done(b, len))
               open_payload(len, meta_kind == mtep_pkg::META_TEMPO &&
                                 len == mtep_pkg::TEMPO_LEN);
         end
         mtep_pkg::PH_SYSEX_LEN: begin
            if (vlq_done(b, len))
               open_payload(len, 1'b0);
         end
         mtep_pkg::PH_PAYLOAD: begin
            if (tempo_meta)
               tempo_acc = {tempo_acc[15:0], b};
            skip_left = skip_left - 28'd1;
            if (skip_left == 28'd0) begin
               phase = mtep_pkg::PH_DELTA;
               if (tempo_meta) begin
                  tempo_meta = 1'b0;
                  push_event(mtep_pkg::EV_TEMPO, 8'h00, 8'h00, tempo_acc);
               end
            end
         end
         mtep_pkg::PH_SKIP_ONE: phase = mtep_pkg::PH_DELTA;
         default: begin
            if (vlq_done(b, len)) begin
               tick  = tick + {4'h0, len};
               phase = mtep_pkg::PH_STATUS;
            end else begin
               phase = mtep_pkg::PH_DELTA;
            end
         end
      endcase
   endfunction

   function automatic int field_differs(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         return 1;
      end
      return 0;
   endfunction

   function automatic void check_event();
      track_event_type want;
      int              bad;
      if (predicted_events.size() == 0) begin
         $display("%0t: event with nothing expected, expected none, actual kind %0d tick 0x%0h",
                  $time, rsp_bus.event_kind, rsp_bus.event_tick);
         errors++;
      end else begin
         want = predicted_events.pop_front();
         bad  = 0;
         bad += field_differs("event_kind", 32'(want.kind), 32'(rsp_bus.event_kind));
         bad += field_differs("event_tick", want.tick, rsp_bus.event_tick);
         bad += field_differs("note_pitch", 32'(want.pitch), 32'(rsp_bus.note_pitch));
         bad += field_differs("note_velocity", 32'(want.velocity),
                              32'(rsp_bus.note_velocity));
         bad += field_differs("tempo_us_per_beat", 32'(want.tempo),
                              32'(rsp_bus.tempo_us_per_beat));
         if (bad != 0)
            errors++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_parser();
         predicted_events.delete();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready)
            check_event();
         if (req_bus.valid && req_bus.ready)
            predict_byte(req_bus.data_byte, req_bus.track_start);
      end
      fail_count    <= errors;
      pending_count <= predicted_events.size();
   end

endmodule

// File: verif/midi_track_event_parser_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_track_event_parser_unit_test
// Feeds track chunk bytes to the parser: a short directed track through the
// corner cases, then random events, mostly well formed, with noise, track
// restarts and random idling on both channels. The checker beside the block
// predicts and compares; this module drives stimulus and gives the verdict.
// ----------------------------------------------------------------------------

module midi_track_event_parser_unit_test;

   localparam int RANDOM_ITEMS = 1950;
   localparam int IDLE_PCT     = 11;
   localparam int STALL_LIMIT  = 4000;
   localparam int HOLD_AT      = 1300;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 8;

   localparam logic [7:0] SYS_FIRST_UNDEF = 8'hF1;
   localparam logic [7:0] SYS_LAST_UNDEF  = 8'hFE;
   localparam logic [7:0] SYS_UNDEF_PICK  = 8'hF4;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_count;
   int   bytes_sent   = 0;
   bit   begin_track  = 1'b0;
   bit   no_idle      = 1'b0;

   mtep_req_if req_bus();
   mtep_rsp_if rsp_bus();

   midi_track_event_parser_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   mtep_event_checker event_check (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .rsp_bus       (rsp_bus),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // one byte transaction; begin_track marks the first byte of a track
   task automatic send_byte(input logic [7:0] value);
      @(negedge clock);
      while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.data_byte   <= value;
      req_bus.track_start <= begin_track;
      begin_track = 1'b0;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      bytes_sent++;
      no_idle = (bytes_sent >= 600 && bytes_sent < 900);
   endtask

   // variable-length quantity, sometimes padded with leading 0x80 bytes
   task automatic send_vlq(input logic [27:0] value);
      int n;
      int i;
      n = 1;
      while (n < 4 && (value >> (7 * n)) != 0) n++;
      if (n < 4 && $urandom_range(9) == 0)
         n = $urandom_range(4, n);
      for (i = n - 1; i >= 0; i--)
         send_byte({(i != 0), value[7 * i +: 7]});
   endtask

   function automatic logic [7:0] param_byte();
      if ($urandom_range(19) == 0)
         return 8'($urandom_range(255));
      return 8'($urandom_range(127));
   endfunction

   task automatic send_random_event();
      int         pick;
      int         len;
      logic [3:0] cmd;
      logic [7:0] status;
      if ($urandom_range(199) == 0)
         begin_track = 1'b1;

      pick = $urandom_range(99);
      if (pick < 5)
         repeat (4) send_byte({1'b1, 7'($urandom_range(127))});
      else if (pick < 55)
         send_vlq(28'($urandom_range(127)));
      else if (pick < 75)
         send_vlq(28'($urandom_range(16383)));
      else
         send_vlq(28'($urandom));

      pick = $urandom_range(99);
      if (pick < 40) begin
         // note event, status left out half the time
         if ($urandom_range(1) == 1)
            send_byte({($urandom_range(1) == 1) ? mtep_pkg::CMD_NOTE_ON
                                                : mtep_pkg::CMD_NOTE_OFF,
                       4'($urandom_range(15))});
         send_byte(param_byte());
         send_byte(($urandom_range(4) == 0) ? 8'h00 : param_byte());
      end else if (pick < 55) begin
         case ($urandom_range(4))
            0: cmd = mtep_pkg::CMD_POLY_AT;
            1: cmd = mtep_pkg::CMD_CONTROL;
            2: cmd = mtep_pkg::CMD_PROGRAM;
            3: cmd = mtep_pkg::CMD_CHAN_AT;
            default: cmd = mtep_pkg::CMD_PITCH;
         endcase
         if ($urandom_range(3) != 0)
            send_byte({cmd, 4'($urandom_range(15))});
         send_byte(param_byte());
         if (cmd != mtep_pkg::CMD_PROGRAM && cmd != mtep_pkg::CMD_CHAN_AT)
            send_byte(param_byte());
      end else if (pick < 70) begin
         len = ($urandom_range(9) == 0) ? int'($urandom_range(6))
                                        : int'(mtep_pkg::TEMPO_LEN);
         send_byte(mtep_pkg::BYTE_META);
         send_byte(mtep_pkg::META_TEMPO);
         send_vlq(28'(len));
         repeat (len) send_byte(8'($urandom_range(255)));
      end else if (pick < 80) begin
         len = $urandom_range(5);
         send_byte(mtep_pkg::BYTE_META);
         send_byte(8'($urandom_range(127)));
         send_vlq(28'(len));
         repeat (len) send_byte(8'($urandom_range(255)));
      end else if (pick < 88) begin
         len = ($urandom_range(19) == 0) ? $urandom_range(300, 128) : $urandom_range(5);
         send_byte(($urandom_range(1) == 1) ? mtep_pkg::BYTE_SYSEX
                                            : mtep_pkg::BYTE_SYSEX_ESC);
         send_vlq(28'(len));
         repeat (len) send_byte(8'($urandom_range(255)));
      end else if (pick < 93) begin
         do status = 8'($urandom_range(SYS_LAST_UNDEF, SYS_FIRST_UNDEF));
         while (status == mtep_pkg::BYTE_SYSEX_ESC);
         send_byte(status);
         send_byte(8'($urandom_range(255)));
      end else if (pick < 95) begin
         // event cut short by a new track
         send_byte({mtep_pkg::CMD_NOTE_ON, 4'($urandom_range(15))});
         send_byte(param_byte());
         begin_track = 1'b1;
      end else begin
         repeat ($urandom_range(3, 1)) send_byte(8'($urandom_range(255)));
      end
   endtask

   task automatic run_directed();
      begin_track = 1'b1;
      send_byte(8'h00);
      send_byte(8'h40);                              // data byte, no running status yet
      send_byte(8'h00);
      send_byte({mtep_pkg::CMD_NOTE_ON, 4'h0});
      send_byte(8'h00);
      send_byte(8'h7F);
      send_byte(8'h00);
      send_byte(8'h3C);                              // running status, velocity zero
      send_byte(8'h00);
      repeat (4) send_byte(8'hFF);                   // delta cut off after four bytes
      send_byte({mtep_pkg::CMD_NOTE_OFF, 4'hF});
      send_byte(8'hFF);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(mtep_pkg::BYTE_META);
      send_byte(mtep_pkg::META_TEMPO);
      send_byte(mtep_pkg::TEMPO_LEN[7:0]);
      repeat (3) send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(SYS_UNDEF_PICK);
      send_byte(8'h55);
      send_byte(8'h00);                              // empty tempo meta, no event
      send_byte(mtep_pkg::BYTE_META);
      send_byte(mtep_pkg::META_TEMPO);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte({mtep_pkg::CMD_NOTE_ON, 4'h3});
      send_byte(8'h3C);
      begin_track = 1'b1;
      send_byte(8'h00);
      send_byte({mtep_pkg::CMD_NOTE_ON, 4'h3});
      send_byte(8'h3C);
      send_byte(8'h40);
   endtask

   // result side: random stalls, one long hold-off partway through the run
   initial begin
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && bytes_sent >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   initial begin
      int stalled;
      stalled = 0;
      while (stalled < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            stalled = 0;
         else
            stalled++;
      end
      $display("midi_track_event_parser_unit verification failed");
      $finish;
   end

   initial begin
      int directed_bytes;
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.data_byte   = 8'h00;
      req_bus.track_start = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_directed();
      directed_bytes = bytes_sent;
      while (bytes_sent < directed_bytes + RANDOM_ITEMS)
         send_random_event();
      @(negedge clock);
      req_bus.valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("midi_track_event_parser_unit verification clean");
      else
         $display("midi_track_event_parser_unit verification failed");
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/mtep_pkg.sv
rtl/mtep_channel_ifs.sv
rtl/mtep_front.sv
rtl/mtep_queue.sv
rtl/mtep_back.sv
rtl/midi_track_event_parser_unit.sv
verif/mtep_event_checker.sv
verif/midi_track_event_parser_unit_test.sv
